>>> src/fcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types and constants for the cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

    localparam logic [15:0] END_MIN  = 16'hFFF8;
    localparam logic [15:0] END_MARK = 16'hFFFF;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_LENGTH = 2'd2;
    localparam logic [1:0] CMD_RESIZE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [0:0] CFG_SHIFT = 1'b0;
    localparam logic [0:0] CFG_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] cluster_index;
        logic [15:0] entry_value;
        logic [31:0] byte_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_value;
        logic [15:0] chain_clusters;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_WALK_RD,
        S_WALK_CHK,
        S_CUT_RD,
        S_CUT_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LINK,
        S_MARK,
        S_DONE
    } t_state;

    // datapath operations selected by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_IDX,
        OP_WR_IDX,
        OP_RD_CUR,
        OP_STEP,
        OP_CUT_START,
        OP_CUT_STEP,
        OP_MARK_CUR,
        OP_FREE_RD,
        OP_FREE_WR,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_LINK,
        OP_MARK_NEW
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       set_result;
        logic [1:0] result_status;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic       clear_last;
        logic       idx_bad;
        logic       rd_end;
        logic       rd_bad;
        logic       len_over;
        logic       cut_now;
        logic       free_go;
        logic       scan_end;
        logic       scan_free;
        logic       need_more;
        logic       shrink;
    } t_status;

endpackage

>>> src/fcce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module fcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fcce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_datapath
// Link table, chain walker registers, free search and result register.
// ----------------------------------------------------------------------------
module fcce_datapath
    import fcce_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic      i_clk,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic      i_rst_n,
    output t_status   o_stat,
    output t_out_item o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    logic [4:0]    r_shift;
    logic [12:0]   r_count;
    t_in_item      r_item;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_nxt;
    logic [AW-1:0] r_scan;
    logic [CW-1:0] r_limit;
    logic [16:0]   r_len;
    logic [16:0]   r_req;
    logic [16:0]   r_cnt;
    t_out_item     r_result;
    t_out_item     r_out;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_rdata;

    logic [4:0]    shift_sat;
    logic [32:0]   bytes_up;
    logic [32:0]   req_full;
    logic [16:0]   req_sat;
    logic [CW-1:0] lim_cfg;
    logic [CW:0]   scan_ext;

    fcce_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        shift_sat = r_shift;
        if (r_shift < 5'd9) begin
            shift_sat = 5'd9;
        end else if (r_shift > 5'd16) begin
            shift_sat = 5'd16;
        end
        bytes_up = {1'b0, i_item.byte_count}
                 + ((33'd1 << shift_sat) - 33'd1);
        req_full = bytes_up >> shift_sat;
        // any request above the longest chain behaves the same
        if (req_full > 33'h1FFFF) begin
            req_sat = 17'h1FFFF;
        end else begin
            req_sat = req_full[16:0];
        end
        if (req_full == 33'd0) begin
            req_sat = 17'd1;
        end
        if ({16'd0, r_count} > TABLE_DEPTH) begin
            lim_cfg = CW'(TABLE_DEPTH);
        end else begin
            lim_cfg = CW'(r_count);
        end
        scan_ext = {1'b0, r_scan};
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_cur;
        ram_wdata = 16'd0;
        case (i_cmd.op)
            OP_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_scan;
            end
            OP_RD_IDX:  ram_addr = r_item.cluster_index[AW-1:0];
            OP_WR_IDX: begin
                ram_we    = 1'b1;
                ram_addr  = r_item.cluster_index[AW-1:0];
                ram_wdata = r_item.entry_value;
            end
            OP_RD_CUR:  ram_addr = r_cur;
            OP_MARK_CUR: begin
                ram_we    = 1'b1;
                ram_addr  = r_cur;
                ram_wdata = END_MARK;
            end
            OP_FREE_RD: ram_addr = r_nxt;
            OP_FREE_WR: begin
                ram_we   = 1'b1;
                ram_addr = r_nxt;
            end
            OP_SCAN_RD: ram_addr = r_scan;
            OP_LINK: begin
                ram_we    = 1'b1;
                ram_addr  = r_cur;
                ram_wdata = 16'(r_scan);
            end
            OP_MARK_NEW: begin
                ram_we    = 1'b1;
                ram_addr  = r_scan;
                ram_wdata = END_MARK;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 5'd11;
            r_count <= 13'd4096;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SHIFT) begin
                r_shift <= i_cfg_data[4:0];
            end else begin
                r_count <= i_cfg_data[12:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: r_scan <= r_scan + AW'(1);
                OP_LOAD: begin
                    r_item  <= i_item;
                    r_cur   <= i_item.cluster_index[AW-1:0];
                    r_len   <= 17'd1;
                    r_req   <= req_sat;
                    r_cnt   <= 17'd1;
                    r_limit <= lim_cfg;
                    r_scan  <= AW'(2);
                end
                OP_STEP: begin
                    r_cur <= ram_rdata[AW-1:0];
                    r_len <= r_len + 17'd1;
                end
                OP_CUT_START: r_cur <= r_item.cluster_index[AW-1:0];
                OP_CUT_STEP: begin
                    r_cur <= ram_rdata[AW-1:0];
                    r_cnt <= r_cnt + 17'd1;
                end
                OP_MARK_CUR: r_nxt <= ram_rdata[AW-1:0];
                OP_FREE_WR:  r_nxt <= ram_rdata[AW-1:0];
                OP_SCAN_NEXT: r_scan <= r_scan + AW'(1);
                OP_MARK_NEW: begin
                    r_cur  <= r_scan;
                    r_scan <= r_scan + AW'(1);
                    r_len  <= r_len + 17'd1;
                end
                default: r_cur <= r_cur;
            endcase
            if (i_cmd.set_result) begin
                r_result.read_value <= 16'd0;
                r_result.status     <= i_cmd.result_status;
                r_result.chain_clusters <= 16'd0;
                if (r_item.command == CMD_READ && i_cmd.result_status == ST_OK) begin
                    r_result.read_value <= ram_rdata;
                end
                if ((r_item.command == CMD_LENGTH || r_item.command == CMD_RESIZE)
                        && i_cmd.result_status != ST_BAD) begin
                    if (r_item.command == CMD_RESIZE && r_req < r_len) begin
                        r_result.chain_clusters <= r_req[15:0];
                    end else if (r_len[16]) begin
                        r_result.chain_clusters <= 16'hFFFF;
                    end else begin
                        r_result.chain_clusters <= r_len[15:0];
                    end
                end
            end
            if (i_cmd.publish) begin
                r_out <= r_result;
            end
        end
    end

    // rd_bad: link not an end mark and outside the table
    always_comb begin
        o_stat.clear_last = (r_scan == AW'(TABLE_DEPTH - 1));
        o_stat.idx_bad    = ({1'b0, r_item.cluster_index} >= 17'(TABLE_DEPTH));
        o_stat.rd_end     = (ram_rdata >= END_MIN);
        o_stat.rd_bad     = (ram_rdata < END_MIN)
                          && ({1'b0, ram_rdata} >= 17'(TABLE_DEPTH));
        o_stat.len_over   = (r_len >= 17'(TABLE_DEPTH));
        o_stat.shrink     = (r_req < r_len);
        o_stat.cut_now    = (r_cnt >= r_req);
        o_stat.free_go    = (ram_rdata < END_MIN)
                          && ({1'b0, ram_rdata} < 17'(TABLE_DEPTH));
        o_stat.scan_end   = (scan_ext >= {1'b0, r_limit}) || (r_scan < AW'(2));
        o_stat.scan_free  = (ram_rdata == 16'd0);
        o_stat.need_more  = (r_len < r_req);
    end

    assign o_result = r_out;

endmodule

>>> src/fcce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_ctrl
// Command sequencer for table clear, walk, cut, free and allocate.
// ----------------------------------------------------------------------------
module fcce_ctrl
    import fcce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic [1:0] i_command,
    input  logic    i_out_ready,
    input  t_status i_stat,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic [1:0] r_command;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_command   <= CMD_READ;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_IDLE && i_in_valid) begin
                r_command <= i_command;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '{op: OP_NONE, set_result: 1'b0, result_status: ST_OK,
                        publish: 1'b0};
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.idx_bad) begin
                    o_cmd.set_result    = 1'b1;
                    o_cmd.result_status = ST_BAD;
                    n_state = S_DONE;
                end else if (r_command == CMD_WRITE) begin
                    o_cmd.op            = OP_WR_IDX;
                    o_cmd.set_result    = 1'b1;
                    n_state = S_DONE;
                end else if (r_command == CMD_READ) begin
                    o_cmd.op = OP_RD_IDX;
                    n_state  = S_RD_WAIT;
                end else begin
                    o_cmd.op = OP_RD_CUR;
                    n_state  = S_WALK_CHK;
                end
            end
            S_RD_WAIT: begin
                o_cmd.set_result = 1'b1;
                n_state = S_DONE;
            end
            S_WALK_RD: begin
                o_cmd.op = OP_RD_CUR;
                n_state  = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (i_stat.rd_end) begin
                    if (r_command == CMD_LENGTH) begin
                        o_cmd.set_result = 1'b1;
                        n_state = S_DONE;
                    end else if (i_stat.shrink) begin
                        o_cmd.op = OP_CUT_START;
                        n_state  = S_CUT_RD;
                    end else begin
                        n_state = S_SCAN_RD;
                        if (!i_stat.need_more) begin
                            o_cmd.set_result = 1'b1;
                            n_state = S_DONE;
                        end
                    end
                end else if (i_stat.rd_bad || i_stat.len_over) begin
                    o_cmd.set_result    = 1'b1;
                    o_cmd.result_status = ST_BAD;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state  = S_WALK_RD;
                end
            end
            S_CUT_RD: begin
                o_cmd.op = OP_RD_CUR;
                n_state  = S_CUT_CHK;
            end
            S_CUT_CHK: begin
                if (i_stat.cut_now) begin
                    o_cmd.op = OP_MARK_CUR;
                    n_state  = S_FREE_CHK;
                end else begin
                    o_cmd.op = OP_CUT_STEP;
                    n_state  = S_CUT_RD;
                end
            end
            S_FREE_CHK: begin
                // r_nxt was captured from the link before marking
                o_cmd.op = OP_FREE_RD;
                n_state  = S_FREE_RD;
            end
            S_FREE_RD: begin
                // free this entry, stop once its link ends the tail
                o_cmd.op = OP_FREE_WR;
                n_state  = S_FREE_CHK;
                if (!i_stat.free_go) begin
                    o_cmd.set_result = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.set_result    = 1'b1;
                    o_cmd.result_status = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.scan_free) begin
                    o_cmd.op = OP_LINK;
                    n_state  = S_MARK;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = S_SCAN_RD;
                end
            end
            S_MARK: begin
                o_cmd.op = OP_MARK_NEW;
                n_state  = S_LINK;
            end
            S_LINK: begin
                if (i_stat.need_more) begin
                    n_state = S_SCAN_RD;
                end else begin
                    o_cmd.set_result = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> (r_state == S_IDLE))
        else $error("done did not return to idle");
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result without done");
`endif

endmodule

>>> src/fat_cluster_chain_engine_unit.sv
`timescale 1ns / 1ps
// resize: walks the chain, then cuts and frees its tail or scans for free entries
//   and links them, all through one table memory port
// one command in flight; a finished result waits in an output register while
//   the next transfer is accepted, and a second finished result stalls
// reset: synchronous active low, then a clear pass of the whole table
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_unit
// FAT16 link table engine: read, write, chain length and resize.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_unit
    import fcce_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    t_cmd    cmd;
    t_status stat;

    fcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_command  (i_data.command),
        .i_out_ready(i_ready),
        .i_stat     (stat),
        .o_in_ready (o_ready),
        .o_out_valid(o_valid),
        .o_cmd      (cmd)
    );

    fcce_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_item     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data ({3'd0, i_cfg_data}),
        .i_rst_n    (i_rst_n),
        .o_stat     (stat),
        .o_result   (o_data)
    );

endmodule

>>> bench/fat_cluster_chain_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_unit_test
// Drives read, write, length and resize commands through the link table
// engine and compares each result against a local model of the table or a fixed value.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_unit_test;
    import fcce_pkg::*;

    localparam int DEPTH = 4096;

    typedef struct {
        t_in_item  cmd;
        logic      fixed;
        t_out_item res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_data;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    fat_cluster_chain_engine_unit #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [15:0] links [DEPTH];
    logic [4:0]  shift_reg;
    logic [12:0] count_reg;
    t_out_item   pending [$];
    int          mismatches;
    int          checked;
    int          sent;
    bit          quiet;
    bit          long_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [1:0] walk(input int head, output int len, output int last);
        int c;
        int n;
        len = 0;
        last = 0;
        if (head >= DEPTH) return ST_BAD;
        c = head;
        n = 1;
        while (links[c] < END_MIN) begin
            c = links[c];
            if (c >= DEPTH) return ST_BAD;
            n++;
            if (n > DEPTH) return ST_BAD;
        end
        len = n;
        last = c;
        return ST_OK;
    endfunction

    function automatic t_out_item table_step(input t_in_item it);
        t_out_item r;
        int len, last, s, req, lim, scan, c, nxt, t;
        logic [63:0] unit;
        r = '0;
        len = 0;
        case (it.command)
            CMD_READ, CMD_WRITE: begin
                if (it.cluster_index >= DEPTH) r.status = ST_BAD;
                else if (it.command == CMD_READ) r.read_value = links[it.cluster_index];
                else links[it.cluster_index] = it.entry_value;
            end
            CMD_LENGTH: begin
                r.status = walk(it.cluster_index, len, last);
            end
            default: begin
                r.status = walk(it.cluster_index, len, last);
                if (r.status == ST_OK) begin
                    s = shift_reg < 9 ? 9 : (shift_reg > 16 ? 16 : shift_reg);
                    unit = 64'd1 << s;
                    req = int'((64'(it.byte_count) + unit - 1) >> s);
                    if (req == 0) req = 1;
                    if (req < len) begin
                        c = it.cluster_index;
                        for (int i = 1; i < req; i++) c = links[c];
                        nxt = links[c];
                        links[c] = END_MARK;
                        while (nxt < END_MIN && nxt < DEPTH) begin
                            t = links[nxt];
                            links[nxt] = '0;
                            nxt = t;
                        end
                        len = req;
                    end else begin
                        lim = count_reg > DEPTH ? DEPTH : count_reg;
                        scan = 2;
                        c = last;
                        while (len < req && r.status == ST_OK) begin
                            while (scan < lim && links[scan] != 0) scan++;
                            if (scan >= lim) begin
                                r.status = ST_FULL;
                            end else begin
                                links[c] = 16'(scan);
                                links[scan] = END_MARK;
                                c = scan;
                                scan++;
                                len++;
                            end
                        end
                    end
                end
            end
        endcase
        if (r.status == ST_BAD) len = 0;
        r.chain_clusters = len > 65535 ? 16'hFFFF : 16'(len);
        return r;
    endfunction

    task automatic send(input t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic issue(input t_in_item it);
        pending.push_back(table_step(it));
        send(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SHIFT) shift_reg = val[4:0];
        else count_reg = val;
    endtask

    function automatic t_in_item mk(input logic [1:0] c, input logic [15:0] idx,
                                    input logic [15:0] v, input logic [31:0] b);
        t_in_item it;
        it.command = c;
        it.cluster_index = idx;
        it.entry_value = v;
        it.byte_count = b;
        return it;
    endfunction

    function automatic t_out_item res(input logic [15:0] rv, input logic [15:0] cc,
                                      input logic [1:0] st);
        t_out_item r;
        r.read_value = rv;
        r.chain_clusters = cc;
        r.status = st;
        return r;
    endfunction

    // result side: random stalls and one long hold
    initial begin
        int gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (long_hold) begin
                long_hold = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 17);
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %p", o_data);
            end else begin
                want = pending.pop_front();
                if (o_data.read_value !== want.read_value
                        || o_data.chain_clusters !== want.chain_clusters
                        || o_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %p got %p", checked, want, o_data);
                end
            end
        end
    end

    t_row rows [$];

    task automatic random_phase(input int n);
        t_in_item it;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            it = mk(CMD_READ, 16'($urandom_range(0, DEPTH - 1)), 16'($urandom),
                    $urandom);
            if (k < 15) begin
                it.command = CMD_READ;
            end else if (k < 30) begin
                it.command = CMD_WRITE;
                case ($urandom_range(0, 3))
                    0: it.entry_value = 16'hFFF8 + 16'($urandom_range(0, 7));
                    1: it.entry_value = 16'($urandom_range(0, DEPTH - 1));
                    2: it.entry_value = 16'h0000;
                    default: ;
                endcase
            end else if (k < 50) begin
                it.command = CMD_LENGTH;
            end else begin
                it.command = CMD_RESIZE;
                it.cluster_index = 16'($urandom_range(2, 40));
                case ($urandom_range(0, 4))
                    0: it.byte_count = $urandom_range(0, 20000);
                    1: it.byte_count = $urandom_range(0, 200000);
                    2: it.byte_count = 32'($urandom_range(0, 4)) << shift_reg;
                    3: it.byte_count = 32'd0;
                    default: it.byte_count = $urandom_range(0, 2000);
                endcase
            end
            if ($urandom_range(0, 40) == 0) it.cluster_index = 16'($urandom);
            issue(it);
        end
    endtask

    initial begin
        t_out_item got;
        mismatches = 0;
        checked = 0;
        sent = 0;
        quiet = 1'b0;
        long_hold = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SHIFT;
        i_cfg_data = '0;
        for (int i = 0; i < DEPTH; i++) links[i] = '0;
        shift_reg = 5'd11;
        count_reg = 13'd4096;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows.push_back('{mk(CMD_READ, 16'd0, 16'd0, 0), 1, res(16'd0, 16'd0, ST_OK)});
        rows.push_back('{mk(CMD_READ, 16'hFFFF, 16'd0, 0), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_WRITE, 16'd4096, 16'hFFFF, 0), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_LENGTH, 16'd4096, 16'd0, 0), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_RESIZE, 16'hFFFF, 16'd0, 0), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_WRITE, 16'd4095, 16'hFFFF, 0), 1, res(16'd0, 16'd0, ST_OK)});
        rows.push_back('{mk(CMD_READ, 16'd4095, 16'd0, 0), 1, res(16'hFFFF, 16'd0, ST_OK)});
        rows.push_back('{mk(CMD_WRITE, 16'd10, 16'hFFF8, 0), 0, '0});
        rows.push_back('{mk(CMD_LENGTH, 16'd10, 16'd0, 0), 1, res(16'd0, 16'd1, ST_OK)});
        rows.push_back('{mk(CMD_RESIZE, 16'd10, 16'd0, 32'd10000), 0, '0});
        rows.push_back('{mk(CMD_LENGTH, 16'd10, 16'd0, 0), 0, '0});
        rows.push_back('{mk(CMD_RESIZE, 16'd10, 16'd0, 32'd0), 0, '0});
        rows.push_back('{mk(CMD_RESIZE, 16'd10, 16'd0, 32'd2049), 0, '0});
        rows.push_back('{mk(CMD_WRITE, 16'd20, 16'd20, 0), 0, '0});
        rows.push_back('{mk(CMD_LENGTH, 16'd20, 16'd0, 0), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_RESIZE, 16'd20, 16'd0, 32'd1), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_WRITE, 16'd21, 16'd5000, 0), 0, '0});
        rows.push_back('{mk(CMD_LENGTH, 16'd21, 16'd0, 0), 1, res(16'd0, 16'd0, ST_BAD)});
        rows.push_back('{mk(CMD_WRITE, 16'd20, 16'd0, 0), 0, '0});
        rows.push_back('{mk(CMD_WRITE, 16'd21, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(CMD_LENGTH, 16'd0, 16'd0, 0), 0, '0});
        rows.push_back('{mk(CMD_RESIZE, 16'd10, 16'd0, 32'hFFFFFFFF), 0, '0});
        rows.push_back('{mk(CMD_RESIZE, 16'd10, 16'd0, 32'd1), 0, '0});

        foreach (rows[i]) begin
            got = table_step(rows[i].cmd);
            pending.push_back(rows[i].fixed ? rows[i].res : got);
            send(rows[i].cmd);
        end
        drain();

        // small table, largest clusters: out of space comes quickly
        set_reg(CFG_COUNT, 13'd40);
        set_reg(CFG_SHIFT, 5'd16);
        random_phase(300);
        drain();

        // long hold on results while commands keep coming
        long_hold = 1'b1;
        random_phase(30);
        drain();

        set_reg(CFG_SHIFT, 5'd9);
        set_reg(CFG_COUNT, 13'd3);
        random_phase(200);
        drain();

        set_reg(CFG_SHIFT, 5'd0);
        set_reg(CFG_COUNT, 13'd8191);
        random_phase(300);
        drain();

        set_reg(CFG_SHIFT, 5'd31);
        set_reg(CFG_COUNT, 13'd64);
        random_phase(300);
        drain();

        set_reg(CFG_SHIFT, 5'd12);
        set_reg(CFG_COUNT, 13'd0);
        random_phase(150);
        drain();

        set_reg(CFG_COUNT, 13'd100);
        quiet = 1'b1;
        random_phase(300);
        drain();

        $display("%0d commands sent, %0d results checked over several table settings",
                 sent, checked);
        if (mismatches == 0 && pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/fcce_pkg.sv
src/fcce_ram.sv
src/fcce_datapath.sv
src/fcce_ctrl.sv
src/fat_cluster_chain_engine_unit.sv
bench/fat_cluster_chain_engine_unit_test.sv
